// ===== rtl/pdq_pkg.sv =====
// Shared types, constants and helper functions for the priority deque block.
// Used by the controller, the datapath and the top level. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pdq_pkg;

  // sizing of the queue set
  localparam int NUM_QUEUES  = 4;
  localparam int QUEUE_DEPTH = 16;

  // fixed field widths of the item ports
  localparam int MODE_W = 2;
  localparam int QSEL_W = 2;
  localparam int KEY_W  = 16;
  localparam int TIME_W = 32;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 5;

  // derived widths
  localparam int QIDX_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int MEM_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
  localparam int ADDR_W = $clog2(MEM_DEPTH);

  // operation codes
  localparam logic [MODE_W-1:0] MODE_TAIL = 2'd0;
  localparam logic [MODE_W-1:0] MODE_HEAD = 2'd1;
  localparam logic [MODE_W-1:0] MODE_POP  = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;

  typedef logic [QIDX_W-1:0] qidx_t;
  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ADDR_W-1:0] addr_t;

  // one stored entry
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // controller to datapath commands
  typedef struct packed {
    logic load;   // capture the incoming item and read its head entry
    logic exec;   // update queue state and load the output register
  } ctl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_valid;
  } dp_stat_t;

  // fold the select field onto the existing queues
  function automatic qidx_t q_map(input logic [QSEL_W-1:0] sel);
    logic [QSEL_W:0] v;
    v = {1'b0, sel};
    for (int i = 0; i < (1 << QSEL_W); i++) begin
      if (int'(v) >= NUM_QUEUES) v = v - (QSEL_W + 1)'(NUM_QUEUES);
    end
    return QIDX_W'(v);
  endfunction

  // ring pointer step forward
  function automatic ptr_t ring_next(input ptr_t p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // ring pointer step backward
  function automatic ptr_t ring_prev(input ptr_t p);
    return (p == '0) ? PTR_W'(QUEUE_DEPTH - 1) : p - 1'b1;
  endfunction

  // flat entry address of a slot in a queue
  function automatic addr_t entry_addr(input qidx_t q, input ptr_t slot);
    return ADDR_W'(q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(slot);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/pdq_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module pdq_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pdq_ctrl.sv =====
// Controller state machine for the priority deque block.
// Depends on pdq_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module pdq_ctrl
  import pdq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire logic     out_ready,
  input  wire dp_stat_t stat,
  output ctl_cmd_t      cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state;
  logic state_next;

  // take an item only when no item is in progress
  assign in_ready = (state == ST_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // output register must be free or emptying this cycle
        if (!stat.out_valid || out_ready) begin
          cmd.exec   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pdq_dp.sv =====
// Datapath for the priority deque block: per-queue pointers, counts and
// longest waits, the entry memory and the output register.
// Depends on pdq_pkg and pdq_ram.
`timescale 1ns / 1ps
`default_nettype none

module pdq_dp
  import pdq_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ctl_cmd_t          cmd,
  output dp_stat_t               stat,
  input  wire logic [MODE_W-1:0] mode,
  input  wire logic [QSEL_W-1:0] queue_select,
  input  wire logic [KEY_W-1:0]  user_key,
  input  wire logic [TIME_W-1:0] current_time,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output logic [STAT_W-1:0]      status,
  output logic [KEY_W-1:0]       removed_key,
  output logic [TIME_W-1:0]      removed_wait,
  output logic [TIME_W-1:0]      max_wait,
  output logic [OCC_W-1:0]       occupancy
);

  // per-queue control state
  ptr_t              head [NUM_QUEUES];
  ptr_t              tail [NUM_QUEUES];
  cnt_t              count [NUM_QUEUES];
  logic [TIME_W-1:0] longest [NUM_QUEUES];

  // captured item
  logic [MODE_W-1:0] req_mode;
  qidx_t             req_q;
  logic [KEY_W-1:0]  req_key;
  logic [TIME_W-1:0] req_time;

  // memory interface
  qidx_t  in_q;
  addr_t  rd_addr;
  entry_t rd_entry;
  logic   wr_en;
  addr_t  wr_addr;
  entry_t wr_entry;

  // next values for the selected queue
  ptr_t              head_next;
  ptr_t              tail_next;
  cnt_t              count_next;
  logic [TIME_W-1:0] longest_next;
  ptr_t              slot;
  logic [TIME_W-1:0] wait_val;
  logic [STAT_W-1:0] res_status;
  logic [KEY_W-1:0]  res_key;
  logic [TIME_W-1:0] res_wait;

  // head entry address of the incoming item
  assign in_q    = q_map(queue_select);
  assign rd_addr = entry_addr(in_q, head[in_q]);

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_mode <= mode;
      req_q    <= in_q;
      req_key  <= user_key;
      req_time <= current_time;
    end
  end

  // entry memory
  pdq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_entry),
    .re    (cmd.load),
    .raddr (rd_addr),
    .rdata (rd_entry)
  );

  // operation on the selected queue
  assign wait_val = req_time - rd_entry.stamp;

  always_comb begin
    head_next    = head[req_q];
    tail_next    = tail[req_q];
    count_next   = count[req_q];
    longest_next = longest[req_q];
    slot         = tail[req_q];
    wr_en        = 1'b0;
    res_status   = STATUS_DONE;
    res_key      = '0;
    res_wait     = '0;
    priority if (req_mode == MODE_TAIL || req_mode == MODE_HEAD) begin
      if (int'(count[req_q]) >= QUEUE_DEPTH) begin
        res_status = STATUS_FULL;
      end else begin
        if (req_mode == MODE_TAIL) begin
          slot      = tail[req_q];
          tail_next = ring_next(tail[req_q]);
        end else begin
          slot      = ring_prev(head[req_q]);
          head_next = slot;
        end
        wr_en      = cmd.exec;
        count_next = count[req_q] + 1'b1;
      end
    end else if (req_mode == MODE_POP) begin
      if (count[req_q] == '0) begin
        res_status = STATUS_EMPTY;
      end else begin
        res_key    = rd_entry.key;
        res_wait   = wait_val;
        if (wait_val > longest[req_q]) longest_next = wait_val;
        head_next  = ring_next(head[req_q]);
        count_next = count[req_q] - 1'b1;
      end
    end else begin
      // unused mode code leaves the queue alone
      res_status = STATUS_DONE;
    end
  end

  assign wr_addr        = entry_addr(req_q, slot);
  assign wr_entry.key   = req_key;
  assign wr_entry.stamp = req_time;

  // queue state update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head[i]    <= '0;
        tail[i]    <= '0;
        count[i]   <= '0;
        longest[i] <= '0;
      end
    end else if (cmd.exec) begin
      head[req_q]    <= head_next;
      tail[req_q]    <= tail_next;
      count[req_q]   <= count_next;
      longest[req_q] <= longest_next;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status       <= res_status;
      removed_key  <= res_key;
      removed_wait <= res_wait;
      max_wait     <= longest_next;
      occupancy    <= OCC_W'(count_next);
    end
  end

  assign stat.out_valid = out_valid;

endmodule

`default_nettype wire

// ===== rtl/priority_deque_with_wait_tracking.sv =====
// Top level of the priority deque with wait tracking.
// Depends on pdq_pkg, pdq_ctrl, pdq_dp and pdq_ram.
`timescale 1ns / 1ps
`default_nettype none

// A set of independent ring-buffer deques of key and time-stamp entries.
// Mode 0 appends at the tail, mode 1 pushes in front of the head, mode 2
// pops the head and reports its wait (current time minus stamp, wrapping),
// updating the queue's longest wait. Each item yields one result. One item
// is handled at a time: it is accepted, the head entry is read from the
// entry memory (registered read), and once the output register is free or
// being drained the queue state is updated and the result loaded into the
// output register; only then does the block take a new item. A held result
// stalls the next update, not acceptance.
// The entry memory needs no clearing; the block is ready right after reset.
module priority_deque_with_wait_tracking
  import pdq_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [MODE_W-1:0] mode,
  input  wire logic [QSEL_W-1:0] queue_select,
  input  wire logic [KEY_W-1:0]  user_key,
  input  wire logic [TIME_W-1:0] current_time,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [STAT_W-1:0]      status,
  output logic [KEY_W-1:0]       removed_key,
  output logic [TIME_W-1:0]      removed_wait,
  output logic [TIME_W-1:0]      max_wait,
  output logic [OCC_W-1:0]       occupancy
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // controller
  pdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath
  pdq_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .mode         (mode),
    .queue_select (queue_select),
    .user_key     (user_key),
    .current_time (current_time),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .status       (status),
    .removed_key  (removed_key),
    .removed_wait (removed_wait),
    .max_wait     (max_wait),
    .occupancy    (occupancy)
  );

endmodule

`default_nettype wire

// ===== test/priority_deque_with_wait_tracking_tb.sv =====
// Self-checking testbench for priority_deque_with_wait_tracking.
// Drives random and directed deque items through the valid/ready ports and checks each
// result against an internal deque predictor. Depends on pdq_pkg and the block's RTL.
`timescale 1ns / 1ps

module priority_deque_with_wait_tracking_tb;
  import pdq_pkg::*;

  // mode value the block treats as a no-op
  localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;

  localparam int RANDOM_ITEMS    = 1500;
  localparam int CALM_TAIL       = 150;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int DRAIN_CYCLES    = 12;
  localparam int MAX_REPORTS     = 30;

  typedef struct {
    logic [MODE_W-1:0] op;
    logic [QSEL_W-1:0] qsel;
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] stamp;
  } deque_item_t;

  typedef struct {
    logic [STAT_W-1:0] status;
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] wait_len;
    logic [TIME_W-1:0] max_wait;
    logic [OCC_W-1:0]  occ;
  } deque_result_t;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} traffic_mix_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [MODE_W-1:0] mode = MODE_TAIL;
  logic [QSEL_W-1:0] queue_select = '0;
  logic [KEY_W-1:0]  user_key = '0;
  logic [TIME_W-1:0] current_time = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [STAT_W-1:0] status;
  logic [KEY_W-1:0]  removed_key;
  logic [TIME_W-1:0] removed_wait;
  logic [TIME_W-1:0] max_wait;
  logic [OCC_W-1:0]  occupancy;

  priority_deque_with_wait_tracking u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .queue_select (queue_select),
    .user_key     (user_key),
    .current_time (current_time),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .removed_key  (removed_key),
    .removed_wait (removed_wait),
    .max_wait     (max_wait),
    .occupancy    (occupancy)
  );

  // clock, 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predicted deque state
  ptr_t              deque_head [NUM_QUEUES];
  ptr_t              deque_tail [NUM_QUEUES];
  cnt_t              deque_fill [NUM_QUEUES];
  logic [TIME_W-1:0] longest_wait [NUM_QUEUES];
  logic [KEY_W-1:0]  slot_key [NUM_QUEUES][QUEUE_DEPTH];
  logic [TIME_W-1:0] slot_stamp [NUM_QUEUES][QUEUE_DEPTH];

  deque_item_t   pending_items[$];
  deque_result_t expected_results[$];

  int accepted_count = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int sent_count = 0;
  int stall_cycles = 0;
  int mismatch_count = 0;
  int results_checked = 0;
  int departures = 0;
  int refused_arrivals = 0;
  int empty_departures = 0;
  int noop_items = 0;
  int peak_fill = 0;

  initial begin
    for (int q = 0; q < NUM_QUEUES; q++) begin
      deque_head[q] = '0;
      deque_tail[q] = '0;
      deque_fill[q] = '0;
      longest_wait[q] = '0;
    end
  end

  // one line per mismatch, printing capped
  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_REPORTS) $display("mismatch: %s", msg);
    mismatch_count++;
  endtask

  // apply one accepted item to the predicted deques and queue its result
  task automatic predict_deque_op(input deque_item_t it);
    deque_result_t r;
    int   qi;
    ptr_t slot;
    r.status = STATUS_DONE;
    r.key = '0;
    r.wait_len = '0;
    qi = int'(it.qsel) % NUM_QUEUES;
    case (it.op)
      MODE_TAIL, MODE_HEAD: begin
        if (int'(deque_fill[qi]) >= QUEUE_DEPTH) begin
          r.status = STATUS_FULL;
          refused_arrivals++;
        end else begin
          if (it.op == MODE_TAIL) begin
            slot = deque_tail[qi];
            deque_tail[qi] = ptr_t'((int'(slot) + 1) % QUEUE_DEPTH);
          end else begin
            slot = ptr_t'((int'(deque_head[qi]) + QUEUE_DEPTH - 1) % QUEUE_DEPTH);
            deque_head[qi] = slot;
          end
          slot_key[qi][slot] = it.key;
          slot_stamp[qi][slot] = it.stamp;
          deque_fill[qi] = deque_fill[qi] + 1'b1;
          if (int'(deque_fill[qi]) > peak_fill) peak_fill = int'(deque_fill[qi]);
        end
      end
      MODE_POP: begin
        if (deque_fill[qi] == '0) begin
          r.status = STATUS_EMPTY;
          empty_departures++;
        end else begin
          slot = deque_head[qi];
          r.key = slot_key[qi][slot];
          r.wait_len = it.stamp - slot_stamp[qi][slot];
          if (r.wait_len > longest_wait[qi]) longest_wait[qi] = r.wait_len;
          deque_head[qi] = ptr_t'((int'(slot) + 1) % QUEUE_DEPTH);
          deque_fill[qi] = deque_fill[qi] - 1'b1;
          departures++;
        end
      end
      default: begin
        noop_items++;
      end
    endcase
    r.max_wait = longest_wait[qi];
    r.occ = OCC_W'(deque_fill[qi]);
    expected_results.push_back(r);
  endtask

  function automatic int pick_idle_pct();
    case ($urandom_range(3, 0))
      0: return 0;
      1: return 5;
      2: return 15;
      default: return 35;
    endcase
  endfunction

  task automatic add_item(input logic [MODE_W-1:0] op, input logic [QSEL_W-1:0] qsel,
                          input logic [KEY_W-1:0] key, input logic [TIME_W-1:0] stamp);
    deque_item_t it;
    it.op = op;
    it.qsel = qsel;
    it.key = key;
    it.stamp = stamp;
    pending_items.push_back(it);
  endtask

  // driver: inputs and out_ready change on the falling edge
  always @(negedge clk) begin
    deque_item_t nxt;
    bit          need_item;
    bit          calm;
    if (!rst) begin
      calm = pending_items.size() < CALM_TAIL;
      // the item on the port is gone once every sent item has been accepted
      need_item = !in_valid || (accepted_count == sent_count);
      // sender side
      if (need_item) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() == 0) begin
          in_valid <= 1'b0;
        end else if (!calm && $urandom_range(99, 0) < idle_pct) begin
          send_gap = $urandom_range(12, 0);
          in_valid <= 1'b0;
        end else begin
          nxt = pending_items.pop_front();
          in_valid <= 1'b1;
          mode <= nxt.op;
          queue_select <= nxt.qsel;
          user_key <= nxt.key;
          current_time <= nxt.stamp;
          sent_count++;
          if (sent_count % 80 == 0) begin
            idle_pct = pick_idle_pct();
            stall_pct = pick_idle_pct();
          end
        end
      end
      // receiver side
      if (recv_gap != 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(99, 0) < stall_pct) begin
        recv_gap = $urandom_range(12, 0);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // monitor: both handshakes sampled on the rising edge
  always @(posedge clk) begin
    deque_item_t   seen;
    deque_result_t want;
    bit            progress;
    if (!rst) begin
      progress = 1'b0;
      if (in_valid === 1'b1 && in_ready === 1'b1) begin
        seen.op = mode;
        seen.qsel = queue_select;
        seen.key = user_key;
        seen.stamp = current_time;
        predict_deque_op(seen);
        accepted_count++;
        progress = 1'b1;
      end
      if (out_valid === 1'b1 && out_ready === 1'b1) begin
        progress = 1'b1;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with no item outstanding, status %0d", status));
        end else begin
          want = expected_results.pop_front();
          if (status !== want.status)
            report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                      results_checked, status, want.status));
          if (removed_key !== want.key)
            report_mismatch($sformatf("result %0d removed_key %h, expected %h",
                                      results_checked, removed_key, want.key));
          if (removed_wait !== want.wait_len)
            report_mismatch($sformatf("result %0d removed_wait %h, expected %h",
                                      results_checked, removed_wait, want.wait_len));
          if (max_wait !== want.max_wait)
            report_mismatch($sformatf("result %0d max_wait %h, expected %h",
                                      results_checked, max_wait, want.max_wait));
          if (occupancy !== want.occ)
            report_mismatch($sformatf("result %0d occupancy %0d, expected %0d",
                                      results_checked, occupancy, want.occ));
          results_checked++;
        end
      end
      stall_cycles = progress ? 0 : stall_cycles + 1;
    end
  end

  // watchdog on cycles without any handshake
  initial begin
    wait (stall_cycles >= WATCHDOG_LIMIT);
    $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
    $display("FAIL priority_deque_with_wait_tracking");
    $finish;
  end

  // stimulus, reset and end of run
  initial begin
    traffic_mix_t      mix;
    logic [MODE_W-1:0] op;
    logic [QSEL_W-1:0] focus_q;
    logic [QSEL_W-1:0] qsel;
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] clock_now;
    logic [TIME_W-1:0] stamp;
    bit                focused;
    int                phase_left;
    int                pick;
    int                arrive_cut;

    // directed: empty pop, no-op, extreme keys and stamps, wrapping waits
    add_item(MODE_POP,  2'd0, 16'h0000, 32'd5);
    add_item(MODE_NOP,  2'd1, 16'hFFFF, 32'd6);
    add_item(MODE_TAIL, 2'd0, 16'h0000, 32'h0000_0000);
    add_item(MODE_HEAD, 2'd0, 16'hFFFF, 32'hFFFF_FFFF);
    add_item(MODE_POP,  2'd0, 16'hA5A5, 32'd10);
    add_item(MODE_POP,  2'd0, 16'h5A5A, 32'hFFFF_FFFF);
    add_item(MODE_POP,  2'd0, 16'h0000, 32'd3);
    add_item(MODE_TAIL, 2'd2, 16'h1234, 32'd100);
    // fill one queue from both ends, then one arrival too many
    for (int i = 0; i < QUEUE_DEPTH; i++)
      add_item((i % 2 == 1) ? MODE_HEAD : MODE_TAIL, 2'd3, KEY_W'(16'h0100 + i),
               TIME_W'(1000 + i));
    add_item(MODE_HEAD, 2'd3, 16'hBEEF, 32'd2000);

    // random: phases that favor filling, draining or a balanced mix
    clock_now = 32'hFFFF_FF00;
    phase_left = 0;
    mix = MIX_BALANCED;
    focus_q = '0;
    focused = 1'b0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(90, 30);
        mix = traffic_mix_t'($urandom_range(2, 0));
        focus_q = QSEL_W'($urandom_range(3, 0));
        focused = $urandom_range(99, 0) < 60;
      end
      phase_left--;
      case (mix)
        MIX_FILL:  arrive_cut = 80;
        MIX_DRAIN: arrive_cut = 22;
        default:   arrive_cut = 52;
      endcase
      pick = $urandom_range(99, 0);
      if (pick < 4) op = MODE_NOP;
      else if (pick < arrive_cut) op = $urandom_range(1, 0) ? MODE_HEAD : MODE_TAIL;
      else op = MODE_POP;
      qsel = focused ? focus_q : QSEL_W'($urandom_range(3, 0));
      pick = $urandom_range(99, 0);
      if (pick < 5) key = '0;
      else if (pick < 10) key = '1;
      else key = KEY_W'($urandom());
      // mostly a slowly advancing clock, with jumps and out-of-order stamps
      pick = $urandom_range(99, 0);
      if (pick < 3) begin
        clock_now = $urandom();
        stamp = clock_now;
      end else if (pick < 5) begin
        stamp = $urandom();
      end else begin
        clock_now = clock_now + $urandom_range(40, 0);
        stamp = clock_now;
      end
      add_item(op, qsel, key, stamp);
    end

    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("ran %0d items, checked %0d results: %0d departures, %0d empty departures",
             sent_count, results_checked, departures, empty_departures);
    $display("%0d arrivals refused on a full queue, %0d no-ops, deepest queue %0d entries",
             refused_arrivals, noop_items, peak_fill);
    if (mismatch_count == 0) begin
      $display("PASS priority_deque_with_wait_tracking");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("FAIL priority_deque_with_wait_tracking");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/pdq_pkg.sv
rtl/pdq_ram.sv
rtl/pdq_ctrl.sv
rtl/pdq_dp.sv
rtl/priority_deque_with_wait_tracking.sv
test/priority_deque_with_wait_tracking_tb.sv
